### rtl/cwh_pkg.sv
// Package for the CrapWow string hash block: fold constants and product type.
// No dependencies; used by cwh_fold_unit and crapwow_string_hash.
package cwh_pkg;

    // Multiplier constants of the hash
    localparam logic [31:0] CW_M = 32'h5755_9429;
    localparam logic [31:0] CW_N = 32'h5052_acdb;

    // Byte count that marks a full word
    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

    // Registered 64-bit product, split into halves
    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } cwh_prod_t;

endpackage

### rtl/cwh_fold_unit.sv
// Shared 32x32->64 fold multiplier with registered product.
// Depends on cwh_pkg (constants, product type).
module cwh_fold_unit
(
    input  logic               clk,
    input  logic               en,
    input  logic               use_m,
    input  logic [31:0]        operand,
    output cwh_pkg::cwh_prod_t prod
);

    logic [31:0]        cst;
    cwh_pkg::cwh_prod_t prod_reg;
    cwh_pkg::cwh_prod_t prod_next;

    // constant select and multiply
    assign cst       = use_m ? cwh_pkg::CW_M : cwh_pkg::CW_N;
    assign prod_next = cwh_pkg::cwh_prod_t'({32'd0, operand} * {32'd0, cst});

    // product register, payload only
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/crapwow_string_hash.sv
// Top level of the CrapWow 32-bit string hash: sequencer and accumulators.
// Depends on cwh_pkg and cwh_fold_unit.
//
//  channel | signals                                          | role
//  --------+--------------------------------------------------+-----------------
//  in      | in_valid, in_ready, key_word, word_bytes,        | key words in
//          | key_length, last_word                            |
//  out     | out_valid, out_ready, hash_value                 | hash per message
//  config  | seed_wr_en, seed_wr_data                         | seed write
//
// A word with bytes passes transfer, multiply and fold steps through the one
// shared multiplier; a last word then adds operand prep, multiply and fold,
// and an empty key takes only its transfer and those final steps.
// in_ready is high only while the sequencer is idle.
// A finished hash sits in the output register; a new message may start while
// it waits, and the final fold holds only if the previous hash is still there.
// rst_n clears control state and seed asynchronously.
module crapwow_string_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr_en,
    input  logic [31:0] seed_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] key_word,
    input  logic [2:0]  word_bytes,
    input  logic [31:0] key_length,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_APPLY,
        S_FPREP,
        S_FMUL,
        S_FAPPLY
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] seed_reg, seed_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic        odd_reg, odd_next;
    logic        in_msg_reg, in_msg_next;
    logic        last_reg, last_next;
    logic        use_m_reg, use_m_next;
    logic [31:0] op_reg, op_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] hash_reg, hash_next;

    logic               mul_en;
    cwh_pkg::cwh_prod_t prod;
    logic [31:0]        h_fold, k_fold;
    logic [31:0]        h_start, k_start;
    logic [31:0]        byte_mask;
    logic               in_xfer;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign hash_value = hash_reg;
    assign mul_en    = (state_reg == S_MUL) || (state_reg == S_FMUL);

    // shared multiplier
    cwh_fold_unit u_fold
    (
        .clk     (clk),
        .en      (mul_en),
        .use_m   (use_m_reg),
        .operand (op_reg),
        .prod    (prod)
    );

    // fold of the registered product into the accumulators
    always_comb
    begin
        if (use_m_reg)
        begin
            k_fold = k_reg ^ prod.lo;
            h_fold = h_reg ^ prod.hi;
        end
        else
        begin
            h_fold = h_reg ^ prod.lo;
            k_fold = k_reg ^ prod.hi;
        end
    end

    // byte mask of a partial word
    always_comb
    begin
        case (word_bytes)
            3'd1:    byte_mask = 32'h0000_00ff;
            3'd2:    byte_mask = 32'h0000_ffff;
            3'd3:    byte_mask = 32'h00ff_ffff;
            default: byte_mask = 32'hffff_ffff;
        endcase
    end

    // accumulators at the head of a message
    always_comb
    begin
        if (in_msg_reg)
        begin
            h_start = h_reg;
            k_start = k_reg;
        end
        else
        begin
            h_start = key_length;
            k_start = key_length + seed_reg + cwh_pkg::CW_N;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_wr_en ? seed_wr_data : seed_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        odd_next       = odd_reg;
        in_msg_next    = in_msg_reg;
        last_next      = last_reg;
        use_m_next     = use_m_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hash_next      = hash_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    h_next      = h_start;
                    k_next      = k_start;
                    in_msg_next = 1'b1;
                    last_next   = last_word;
                    if (word_bytes >= cwh_pkg::FULL_WORD_BYTES)
                    begin
                        op_next    = key_word;
                        use_m_next = in_msg_reg ? odd_reg : 1'b0;
                        odd_next   = in_msg_reg ? !odd_reg : 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        odd_next = in_msg_reg ? odd_reg : 1'b0;
                        if (word_bytes != 3'd0)
                        begin
                            op_next    = key_word & byte_mask;
                            use_m_next = 1'b1;
                            state_next = S_MUL;
                        end
                        else if (last_word)
                        begin
                            state_next = S_FPREP;
                        end
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                h_next     = h_fold;
                k_next     = k_fold;
                state_next = last_reg ? S_FPREP : S_IDLE;
            end
            S_FPREP:
            begin
                op_next    = h_reg ^ (k_reg + cwh_pkg::CW_N);
                use_m_next = 1'b0;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                state_next = S_FAPPLY;
            end
            S_FAPPLY:
            begin
                // wait while the previous hash is still untaken
                if (!out_valid_reg || out_ready)
                begin
                    h_next         = h_fold;
                    k_next         = k_fold;
                    hash_next      = k_fold ^ h_fold;
                    out_valid_next = 1'b1;
                    in_msg_next    = 1'b0;
                    odd_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= 32'd0;
            h_reg         <= 32'd0;
            k_reg         <= 32'd0;
            odd_reg       <= 1'b0;
            in_msg_reg    <= 1'b0;
            last_reg      <= 1'b0;
            use_m_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            h_reg         <= h_next;
            k_reg         <= k_next;
            odd_reg       <= odd_next;
            in_msg_reg    <= in_msg_next;
            last_reg      <= last_next;
            use_m_reg     <= use_m_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        hash_reg <= hash_next;
    end

endmodule

### sim/testbench.sv
// Self-checking testbench for crapwow_string_hash: directed keys, then random messages.
// Predicts each hash in a local model of the fold sequence; depends on cwh_pkg and the RTL.
// Varies idling on both channels, seed settings, and includes output back-pressure stalls.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        seed_wr_en = 1'b0;
    logic [31:0] seed_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] key_word = '0;
    logic [2:0]  word_bytes = '0;
    logic [31:0] key_length = '0;
    logic        last_word = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] hash_value;

    // Local copy of the hash state and seed
    logic [31:0] mdl_seed = '0;
    logic [31:0] mdl_h = '0;
    logic [31:0] mdl_k = '0;
    bit          mdl_odd = 1'b0;
    bit          mdl_in_msg = 1'b0;

    logic [31:0] hash_queue[$];

    int          error_count = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          tx_idle_pct = 11;
    int          rx_idle_pct = 47;
    int          hold_left = 0;

    crapwow_string_hash DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_word     (key_word),
        .word_bytes   (word_bytes),
        .key_length   (key_length),
        .last_word    (last_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hash_value   (hash_value)
    );

    // Clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // One 32x32->64 fold; N puts the low half into h, M puts it into k
    function automatic void fold_word(input logic [31:0] w, input bit with_n);
        logic [63:0] p;
        p = {32'd0, w} * {32'd0, (with_n ? cwh_pkg::CW_N : cwh_pkg::CW_M)};
        if (with_n)
        begin
            mdl_h ^= p[31:0];
            mdl_k ^= p[63:32];
        end
        else
        begin
            mdl_k ^= p[31:0];
            mdl_h ^= p[63:32];
        end
    endfunction

    // Advance the hash state by one accepted word; queue the hash on the last one
    function automatic void predict_hash(input logic [31:0] word, input logic [2:0] bytes,
                                         input logic [31:0] len, input logic last);
        logic [31:0] mask;
        int          shift;
        if (!mdl_in_msg)
        begin
            mdl_h      = len;
            mdl_k      = len + mdl_seed + cwh_pkg::CW_N;
            mdl_odd    = 1'b0;
            mdl_in_msg = 1'b1;
        end
        if (bytes >= cwh_pkg::FULL_WORD_BYTES)
        begin
            fold_word(word, !mdl_odd);
            mdl_odd = !mdl_odd;
        end
        else if (bytes != 3'd0)
        begin
            // partial word: mask to its bytes, always folded with M
            shift = 8 * (4 - int'(bytes));
            mask  = 32'hffff_ffff >> shift;
            fold_word(word & mask, 1'b0);
        end
        if (last)
        begin
            fold_word(mdl_h ^ (mdl_k + cwh_pkg::CW_N), 1'b1);
            hash_queue.push_back(mdl_k ^ mdl_h);
            mdl_in_msg = 1'b0;
            mdl_odd    = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s: got %08h expected %08h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Offer one word and hold it until the transfer completes
    task automatic send_word(input logic [31:0] word, input logic [2:0] bytes,
                             input logic [31:0] len, input logic last);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid   <= 1'b1;
        key_word   <= word;
        word_bytes <= bytes;
        key_length <= len;
        last_word  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_hash(word, bytes, len, last);
        items_sent++;
    endtask

    // Stop offering and wait until every hash has arrived and the block has settled
    task automatic wait_for_hashes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (hash_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_seed(input logic [31:0] value);
        seed_wr_en   <= 1'b1;
        seed_wr_data <= value;
        @(posedge clk);
        seed_wr_en <= 1'b0;
        mdl_seed = value;
        @(posedge clk);
    endtask

    // Well-formed key of len bytes: full words, then a partial tail if any
    task automatic send_message(input int unsigned len);
        int unsigned left;
        left = len;
        if (len == 0)
            send_word($urandom, 3'd0, 32'd0, 1'b1);
        while (left > 0)
        begin
            if (left > 4)
            begin
                send_word($urandom, 3'd4, len, 1'b0);
                left -= 4;
            end
            else
            begin
                send_word($urandom, left[2:0], len, 1'b1);
                left = 0;
            end
        end
    endtask

    // Message with random byte counts and a length that need not agree
    task automatic send_broken_message();
        int          n;
        logic [31:0] len;
        n   = $urandom_range(1, 6);
        len = $urandom;
        for (int i = 0; i < n; i++)
            send_word($urandom, 3'($urandom_range(0, 7)), len, i == n - 1);
    endtask

    // Receive side: check each transfer against the oldest queued hash
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready)
        begin
            if (hash_queue.size() == 0)
                report_mismatch("hash with none expected", hash_value, 32'hx);
            else
            begin
                if (hash_value !== hash_queue[0])
                    report_mismatch("hash_value", hash_value, hash_queue[0]);
                void'(hash_queue.pop_front());
            end
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Run limit
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL crapwow_string_hash");
        $finish;
    end

    task automatic test_empty_key();
        send_word(32'h0000_0000, 3'd0, 32'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd0, 32'd0, 1'b1);
    endtask

    // Single full word, then two words to see the N/M alternation
    task automatic test_full_words();
        send_word(32'hffff_ffff, 3'd4, 32'd4, 1'b1);
        send_word(32'h0000_0000, 3'd4, 32'd8, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 32'd8, 1'b1);
    endtask

    task automatic test_partial_tails();
        for (int b = 1; b <= 3; b++)
            send_word(32'hffff_ffff, 3'(b), 32'(b), 1'b1);
    endtask

    // Byte counts above four behave as full words; run with the all-ones seed
    task automatic test_oversize_counts();
        wait_for_hashes();
        load_seed(32'hffff_ffff);
        for (int b = 5; b <= 7; b++)
            send_word($urandom, 3'(b), 32'd4, 1'b1);
    endtask

    // Zero-byte words: first word still starts the message, later ones are skipped
    task automatic test_zero_bytes_mid();
        send_word($urandom, 3'd0, 32'd6, 1'b0);
        send_word($urandom, 3'd4, 32'd6, 1'b0);
        send_word($urandom, 3'd0, 32'd6, 1'b0);
        send_word($urandom, 3'd2, 32'd6, 1'b1);
    endtask

    // Partial word ahead of full words leaves the alternation on N
    task automatic test_partial_not_last();
        send_word($urandom, 3'd2, 32'd10, 1'b0);
        send_word($urandom, 3'd4, 32'd10, 1'b0);
        send_word($urandom, 3'd4, 32'd10, 1'b1);
    endtask

    task automatic test_length_mismatch();
        send_word($urandom, 3'd4, 32'hffff_ffff, 1'b1);
        send_word($urandom, 3'd4, 32'd0, 1'b0);
        send_word($urandom, 3'd3, 32'd0, 1'b1);
    endtask

    // New seed loaded between words: used only from the next message on
    task automatic test_seed_mid_message();
        send_word($urandom, 3'd4, 32'd8, 1'b0);
        wait_for_hashes();
        load_seed($urandom);
        send_word($urandom, 3'd4, 32'd8, 1'b1);
        send_word($urandom, 3'd2, 32'd2, 1'b1);
    endtask

    // Long receiver hold-off while the sender keeps offering short keys
    task automatic test_receiver_holdoff();
        wait_for_hashes();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = 400;
        repeat (30) send_message($urandom_range(0, 8));
    endtask

    // Sender goes quiet until every hash is back, then resumes
    task automatic test_sender_pause();
        tx_idle_pct = 11;
        rx_idle_pct = 47;
        repeat (5) send_message($urandom_range(0, 16));
        wait_for_hashes();
        repeat (5) send_message($urandom_range(0, 16));
    endtask

    // Mostly well-formed keys of random content, with some broken messages
    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [31:0] seed_value, input int count);
        int start;
        wait_for_hashes();
        load_seed(seed_value);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = items_sent;
        while (items_sent - start < count)
        begin
            if ($urandom_range(9) == 0)
                send_broken_message();
            else if ($urandom_range(19) == 0)
                send_message($urandom_range(25, 200));
            else
                send_message($urandom_range(0, 24));
        end
    endtask

    // Test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_key();
        test_full_words();
        test_partial_tails();
        test_oversize_counts();
        test_zero_bytes_mid();
        test_partial_not_last();
        test_length_mismatch();
        test_seed_mid_message();
        test_receiver_holdoff();
        test_sender_pause();
        test_random_traffic(11, 47, $urandom, PHASE_ITEMS);
        test_random_traffic(47, 11, 32'hffff_ffff, PHASE_ITEMS);
        test_random_traffic(0, 0, 32'h0000_0000, PHASE_ITEMS);

        wait_for_hashes();
        if (error_count == 0)
            $display("PASS crapwow_string_hash");
        else
            $display("FAIL crapwow_string_hash");
        $finish;
    end

endmodule
